FILE: rtl/core/nir_pkg.sv
`default_nettype none

package nir_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_TIME  = 1'b0,
    CFG_CHECK_ADDR = 1'b1
  } cfg_reg_e;

  localparam int unsigned UNIT_W     = 11;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FRAME_BITS = 32;
  localparam int unsigned BITCNT_W   = 6;

  localparam logic [UNIT_W-1:0] UNIT_RESET = 11'd563;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_FRAME  = 2'd0,
    ST_REPEAT = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  // Decoder phase.
  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_HDR_LOW  = 2'd1,
    PH_BIT_LOW  = 2'd2,
    PH_BIT_HIGH = 2'd3
  } phase_e;

  // A line event after classification against the NEC pulse lengths.
  typedef struct packed {
    logic timeout;
    logic level;
    logic m16;
    logic m8;
    logic m4;
    logic m3;
    logic m1;
  } pulse_class_t;

endpackage

`default_nettype wire

FILE: rtl/core/nir_front.sv
`default_nettype none

module nir_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  input  wire  [nir_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [nir_pkg::UNIT_W-1:0]     cfg_data_i,
  input  wire                            is_timeout_i,
  input  wire                            pulse_level_i,
  input  wire  [nir_pkg::DUR_W-1:0]      pulse_duration_i,
  output nir_pkg::pulse_class_t          class_o,
  output logic                           chk_addr_o
);
  import nir_pkg::*;

  localparam int unsigned TGT_W  = DUR_W + 1;
  localparam int unsigned HALF_W = UNIT_W - 1;

  logic [UNIT_W-1:0] unit_q;
  logic              chk_addr_q;
  logic [HALF_W-1:0] half;
  logic [TGT_W-1:0]  tgt16, tgt8, tgt4, tgt3, tgt1;

  // True when the duration lies strictly inside target plus or minus half a unit.
  function automatic logic dur_match(input logic [DUR_W-1:0] dur,
                                     input logic [TGT_W-1:0] target,
                                     input logic [HALF_W-1:0] hw);
    logic [TGT_W-1:0] lo;
    logic [TGT_W-1:0] hi;
    lo = target - {{(TGT_W-HALF_W){1'b0}}, hw};
    hi = target + {{(TGT_W-HALF_W){1'b0}}, hw};
    return ({1'b0, dur} > lo) && ({1'b0, dur} < hi);
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q     <= UNIT_RESET;
      chk_addr_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_UNIT_TIME) begin
        unit_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_CHECK_ADDR) begin
        chk_addr_q <= cfg_data_i[0];
      end
    end
  end

  // Target lengths are shifts and one add of the unit.
  assign half  = unit_q[UNIT_W-1:1];
  assign tgt16 = {2'b0, unit_q, 4'b0};
  assign tgt8  = {3'b0, unit_q, 3'b0};
  assign tgt4  = {4'b0, unit_q, 2'b0};
  assign tgt3  = {5'b0, unit_q, 1'b0} + {6'b0, unit_q};
  assign tgt1  = {6'b0, unit_q};

  // Classify the incoming beat.
  always_comb begin
    class_o.timeout = is_timeout_i;
    class_o.level   = pulse_level_i;
    class_o.m16     = dur_match(pulse_duration_i, tgt16, half);
    class_o.m8      = dur_match(pulse_duration_i, tgt8, half);
    class_o.m4      = dur_match(pulse_duration_i, tgt4, half);
    class_o.m3      = dur_match(pulse_duration_i, tgt3, half);
    class_o.m1      = dur_match(pulse_duration_i, tgt1, half);
  end

  assign chk_addr_o = chk_addr_q;

endmodule

`default_nettype wire

FILE: rtl/core/nir_queue.sv
`default_nettype none

module nir_queue (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  nir_pkg::pulse_class_t  data_i,
  output logic                   full_o,
  input  wire                    pop_i,
  output logic                   empty_o,
  output nir_pkg::pulse_class_t  data_o
);
  import nir_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pulse_class_t     slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nir_back.sv
`default_nettype none

module nir_back (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            empty_i,
  input  nir_pkg::pulse_class_t          class_i,
  output logic                           pop_o,
  input  wire                            chk_addr_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [nir_pkg::STATUS_W-1:0]   status_o,
  output logic [nir_pkg::BYTE_W-1:0]     address_o,
  output logic [nir_pkg::BYTE_W-1:0]     command_o
);
  import nir_pkg::*;

  phase_e                phase_q, phase_d;
  logic [BITCNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d, shift_new;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [BYTE_W-1:0]     address_q, command_q;
  logic                  emit;
  status_e               emit_status;
  logic [BYTE_W-1:0]     emit_addr, emit_cmd;
  logic                  step;
  logic                  last_bit;
  logic                  cmd_ok, addr_ok;

  // Advance when an event waits and the output register can take a result.
  assign step  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = step;

  assign shift_new = shift_q | (FRAME_BITS'(class_i.m3) << bit_cnt_q[4:0]);
  assign last_bit  = (bit_cnt_q == BITCNT_W'(FRAME_BITS - 1));
  assign cmd_ok    = (shift_new[23:16] == ~shift_new[31:24]);
  assign addr_ok   = !chk_addr_i || (shift_new[7:0] == ~shift_new[15:8]);

  // Decoder state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      bit_cnt_q <= '0;
      shift_q   <= '0;
    end else if (step) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      shift_q   <= shift_d;
    end
  end

  // Next phase and result for the event at the head of the queue.
  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    emit        = 1'b0;
    emit_status = ST_ERROR;
    emit_addr   = '0;
    emit_cmd    = '0;
    case (phase_q)
      PH_IDLE: begin
        if (!class_i.timeout && !class_i.level && class_i.m16) begin
          phase_d = PH_HDR_LOW;
        end else begin
          emit = 1'b1;
        end
      end
      PH_HDR_LOW: begin
        if (class_i.timeout) begin
          phase_d = PH_IDLE;
        end else if (class_i.level && class_i.m8) begin
          phase_d   = PH_BIT_LOW;
          bit_cnt_d = '0;
          shift_d   = '0;
        end else if (class_i.level && class_i.m4) begin
          emit        = 1'b1;
          emit_status = ST_REPEAT;
        end else begin
          emit = 1'b1;
        end
      end
      PH_BIT_LOW: begin
        if (!class_i.timeout && !class_i.level && class_i.m1) begin
          phase_d = PH_BIT_HIGH;
        end else begin
          emit = 1'b1;
        end
      end
      PH_BIT_HIGH: begin
        if (class_i.timeout || !class_i.level || !(class_i.m3 || class_i.m1)) begin
          emit = 1'b1;
        end else if (!last_bit) begin
          phase_d   = PH_BIT_LOW;
          bit_cnt_d = bit_cnt_q + 1'b1;
          shift_d   = shift_new;
        end else begin
          emit = 1'b1;
          if (cmd_ok && addr_ok) begin
            emit_status = ST_FRAME;
            emit_addr   = shift_new[7:0];
            emit_cmd    = shift_new[23:16];
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    // Every result sends the decoder back to idle.
    if (emit) begin
      phase_d   = PH_IDLE;
      bit_cnt_d = '0;
      shift_d   = '0;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      status_q  <= emit_status;
      address_q <= emit_addr;
      command_q <= emit_cmd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign address_o   = address_q;
  assign command_o   = command_q;

endmodule

`default_nettype wire

FILE: rtl/core/nec_ir_frame_decoder.sv
// An input beat is held in the event queue and its result in the output register.
// Throughput: one line event per cycle; the two-entry event queue and the output
// register let the classifier and the frame state machine stall independently.
// Reset: queue empty, decoder idle with no bits held, no result pending,
// unit time 563 us and the address inverse check off.
`default_nettype none

module nec_ir_frame_decoder (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [nir_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [nir_pkg::UNIT_W-1:0]     cfg_data_i,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            is_timeout_i,
  input  wire                            pulse_level_i,
  input  wire  [nir_pkg::DUR_W-1:0]      pulse_duration_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [nir_pkg::STATUS_W-1:0]   status_o,
  output logic [nir_pkg::BYTE_W-1:0]     address_o,
  output logic [nir_pkg::BYTE_W-1:0]     command_o
);
  import nir_pkg::*;

  pulse_class_t in_class, head_class;
  logic         chk_addr;
  logic         q_full, q_empty, q_pop;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;

  // Front: configuration registers and pulse classification.
  nir_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .is_timeout_i     (is_timeout_i),
    .pulse_level_i    (pulse_level_i),
    .pulse_duration_i (pulse_duration_i),
    .class_o          (in_class),
    .chk_addr_o       (chk_addr)
  );

  // Event queue between the two halves.
  nir_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (in_class),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (head_class)
  );

  // Back: frame state machine and result register.
  nir_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .class_i     (head_class),
    .pop_o       (q_pop),
    .chk_addr_i  (chk_addr),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .address_o   (address_o),
    .command_o   (command_o)
  );

endmodule

`default_nettype wire
